// File: rtl/fcg_pkg.sv
// Package for the floor/ceiling texel generator: widths, register indexes,
// controller states, command/status structs and the texel function.
// No dependencies.
`default_nettype none

package fcg_pkg;

    localparam int TEX_SIZE   = 64;
    localparam int MAX_DIM    = 4096;
    localparam int TEX_LIMIT  = 50;

    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int FIX_W      = 32;
    localparam int DIR_W      = 16;
    localparam int ADDR_W     = 24;
    localparam int TEX_W      = 6;
    localparam int FRAC_W     = 16;
    localparam int TEX_MUL_W  = FRAC_W + 9;
    localparam int TEX_IDX_W  = TEX_MUL_W - FRAC_W;

    localparam int DVD_W      = 32;
    localparam int DVS_W      = DIM_W + 1;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

    localparam int MUL_A_W    = FIX_W + 1;
    localparam int MUL_B_W    = DIR_W + 2;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int Q14_SHIFT  = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAYER_X       = 4'd0,
        REG_PLAYER_Y       = 4'd1,
        REG_VIEW_DIR_X     = 4'd2,
        REG_VIEW_DIR_Y     = 4'd3,
        REG_CAMERA_PLANE_X = 4'd4,
        REG_CAMERA_PLANE_Y = 4'd5,
        REG_SCREEN_WIDTH   = 4'd6,
        REG_SCREEN_HEIGHT  = 4'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_WAIT,
        S_MUL_FX,
        S_MUL_FY,
        S_MUL_SX,
        S_DIV_SX,
        S_SX_WAIT,
        S_SY_WAIT,
        S_TEX,
        S_ADDR_F,
        S_ADDR_C,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_FX,
        MUL_FY,
        MUL_SX,
        MUL_SY,
        MUL_AF,
        MUL_AC
    } mul_sel_t;

    typedef enum logic {
        DIV_ROW,
        DIV_STEP
    } div_src_t;

    typedef struct packed {
        logic     capture;
        logic     res_clear;
        logic     div_load;
        div_src_t div_src;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     rd_load;
        logic     pos_x_load;
        logic     pos_y_load;
        logic     step_x_load;
        logic     step_y_load;
        logic     tex_load;
        logic     floor_load;
        logic     ceil_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic below_horizon;
        logic col_zero;
        logic div_idle;
        logic out_free;
    } status_t;

    // texel index from the fraction of a Q16.16 position; 0 if negative or above 50
    function automatic logic [TEX_W-1:0] texel(input logic [FIX_W-1:0] pos);
        logic [TEX_MUL_W-1:0] scaled;
        logic [TEX_IDX_W-1:0] t;
        scaled = TEX_MUL_W'(pos[FRAC_W-1:0]) * TEX_MUL_W'(TEX_SIZE);
        t      = scaled[TEX_MUL_W-1:FRAC_W];
        if (pos[FIX_W-1] || (t > TEX_IDX_W'(TEX_LIMIT)))
            return '0;
        return t[TEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/fcg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fcg_pkg.
`default_nettype none

module fcg_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [fcg_pkg::DVD_W-1:0]   dividend,
    input  wire logic [fcg_pkg::DVS_W-1:0]   divisor,
    output logic                             idle,
    output logic [fcg_pkg::DVD_W-1:0]        quotient
);

    logic [fcg_pkg::DVD_W-1:0]     quo_reg;
    logic [fcg_pkg::DVD_W-1:0]     quo_next;
    logic [fcg_pkg::DVS_W-1:0]     rem_reg;
    logic [fcg_pkg::DVS_W-1:0]     rem_next;
    logic [fcg_pkg::DVS_W-1:0]     dvs_reg;
    logic [fcg_pkg::DVS_W-1:0]     dvs_next;
    logic [fcg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [fcg_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [fcg_pkg::DVS_W:0]       shifted;
    logic                          ge;
    logic [fcg_pkg::DVS_W:0]       rem_step;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[fcg_pkg::DVD_W-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_step = ge ? (shifted - {1'b0, dvs_reg}) : shifted;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = fcg_pkg::DIV_CNT_W'(fcg_pkg::DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[fcg_pkg::DVD_W-2:0], ge};
            rem_next = rem_step[fcg_pkg::DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign idle     = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/fcg_dp.sv
// Datapath: config registers, row state, shared multiplier, divider,
// result and output registers. Depends on fcg_pkg and fcg_div.
`default_nettype none

module fcg_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [fcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fcg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [fcg_pkg::DIM_W-1:0]         row,
    input  wire logic [fcg_pkg::DIM_W-1:0]         column,
    input  wire fcg_pkg::cmd_t                     cmd,
    output fcg_pkg::status_t                       status,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [fcg_pkg::TEX_W-1:0]              tex_x,
    output logic [fcg_pkg::TEX_W-1:0]              tex_y,
    output logic [fcg_pkg::ADDR_W-1:0]             floor_pixel,
    output logic [fcg_pkg::ADDR_W-1:0]             ceiling_pixel,
    output logic                                   drawn
);

    // config
    logic [fcg_pkg::FIX_W-1:0] px_reg, py_reg;
    logic [fcg_pkg::DIR_W-1:0] dx_reg, dy_reg, cx_reg, cy_reg;
    logic [fcg_pkg::DIM_W-1:0] w_reg, h_reg;

    // row state
    logic [fcg_pkg::FIX_W-1:0] rd_reg, rd_next;
    logic [fcg_pkg::FIX_W-1:0] pos_x_reg, pos_x_next;
    logic [fcg_pkg::FIX_W-1:0] pos_y_reg, pos_y_next;
    logic [fcg_pkg::FIX_W-1:0] step_x_reg, step_x_next;
    logic [fcg_pkg::FIX_W-1:0] step_y_reg, step_y_next;

    // captured item and working values
    logic [fcg_pkg::DIM_W-1:0]        row_reg, col_reg;
    logic signed [fcg_pkg::PROD_W-1:0] prod_reg;
    logic                              step_neg_reg;

    // results
    logic [fcg_pkg::TEX_W-1:0]  res_tx_reg, res_ty_reg;
    logic [fcg_pkg::ADDR_W-1:0] res_floor_reg, res_ceil_reg;
    logic                       res_drawn_reg;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [fcg_pkg::TEX_W-1:0]  out_tx_reg, out_ty_reg;
    logic [fcg_pkg::ADDR_W-1:0] out_floor_reg, out_ceil_reg;
    logic                       out_drawn_reg;

    logic [fcg_pkg::DIM_W-2:0]         half_h;
    logic [fcg_pkg::DIM_W-1:0]         p;
    logic signed [fcg_pkg::MUL_A_W-1:0] mul_a;
    logic signed [fcg_pkg::MUL_B_W-1:0] mul_b;
    logic signed [fcg_pkg::MUL_B_W-1:0] two_cx, two_cy;
    logic signed [fcg_pkg::PROD_W-1:0]  prod_bias;
    logic signed [fcg_pkg::PROD_W-1:0]  prod_q14;
    logic [fcg_pkg::PROD_W-1:0]         prod_mag;
    logic [fcg_pkg::ADDR_W-1:0]         h_row_1;
    logic [fcg_pkg::ADDR_W-1:0]         base;
    logic [fcg_pkg::DVD_W-1:0]          div_dividend;
    logic [fcg_pkg::DVS_W-1:0]          div_divisor;
    logic                               div_idle;
    logic [fcg_pkg::DVD_W-1:0]          div_quotient;
    logic [fcg_pkg::FIX_W-1:0]          step_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            dx_reg <= 16'sd16384;
            dy_reg <= '0;
            cx_reg <= '0;
            cy_reg <= 16'd10813;
            w_reg  <= 12'd640;
            h_reg  <= 12'd480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fcg_pkg::REG_PLAYER_X:       px_reg <= cfg_data;
                fcg_pkg::REG_PLAYER_Y:       py_reg <= cfg_data;
                fcg_pkg::REG_VIEW_DIR_X:     dx_reg <= cfg_data[fcg_pkg::DIR_W-1:0];
                fcg_pkg::REG_VIEW_DIR_Y:     dy_reg <= cfg_data[fcg_pkg::DIR_W-1:0];
                fcg_pkg::REG_CAMERA_PLANE_X: cx_reg <= cfg_data[fcg_pkg::DIR_W-1:0];
                fcg_pkg::REG_CAMERA_PLANE_Y: cy_reg <= cfg_data[fcg_pkg::DIR_W-1:0];
                fcg_pkg::REG_SCREEN_WIDTH:   w_reg  <= cfg_data[fcg_pkg::DIM_W-1:0];
                fcg_pkg::REG_SCREEN_HEIGHT:  h_reg  <= cfg_data[fcg_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        half_h  = h_reg[fcg_pkg::DIM_W-1:1];
        p       = row_reg - {1'b0, half_h};
        h_row_1 = fcg_pkg::ADDR_W'(h_reg) - fcg_pkg::ADDR_W'(row_reg) - 1'b1;
        base    = fcg_pkg::ADDR_W'(w_reg) - fcg_pkg::ADDR_W'(col_reg) - 1'b1;

        two_cx  = {cx_reg[fcg_pkg::DIR_W-1], cx_reg, 1'b0};
        two_cy  = {cy_reg[fcg_pkg::DIR_W-1], cy_reg, 1'b0};

        unique case (cmd.mul_sel)
            fcg_pkg::MUL_FX:
            begin
                mul_a = {1'b0, rd_reg};
                mul_b = {{2{dx_reg[fcg_pkg::DIR_W-1]}}, dx_reg}
                      + {{2{cx_reg[fcg_pkg::DIR_W-1]}}, cx_reg};
            end
            fcg_pkg::MUL_FY:
            begin
                mul_a = {1'b0, rd_reg};
                mul_b = {{2{dy_reg[fcg_pkg::DIR_W-1]}}, dy_reg}
                      + {{2{cy_reg[fcg_pkg::DIR_W-1]}}, cy_reg};
            end
            fcg_pkg::MUL_SX:
            begin
                mul_a = {1'b0, rd_reg};
                mul_b = -two_cx;
            end
            fcg_pkg::MUL_SY:
            begin
                mul_a = {1'b0, rd_reg};
                mul_b = -two_cy;
            end
            fcg_pkg::MUL_AF:
            begin
                mul_a = fcg_pkg::MUL_A_W'(row_reg);
                mul_b = fcg_pkg::MUL_B_W'(w_reg);
            end
            fcg_pkg::MUL_AC:
            begin
                mul_a = fcg_pkg::MUL_A_W'(h_row_1);
                mul_b = fcg_pkg::MUL_B_W'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // truncate toward zero on the divide by 2^14
        prod_bias = prod_reg + (prod_reg[fcg_pkg::PROD_W-1]
                  ? fcg_pkg::PROD_W'((1 << fcg_pkg::Q14_SHIFT) - 1) : '0);
        prod_q14  = prod_bias >>> fcg_pkg::Q14_SHIFT;
        prod_mag  = prod_reg[fcg_pkg::PROD_W-1] ? -prod_reg : prod_reg;

        if (cmd.div_src == fcg_pkg::DIV_ROW)
        begin
            div_dividend = {4'b0, h_reg, 16'b0};
            div_divisor  = {p, 1'b0};
        end
        else
        begin
            div_dividend = prod_mag[fcg_pkg::Q14_SHIFT +: fcg_pkg::DVD_W];
            div_divisor  = (w_reg == '0) ? fcg_pkg::DVS_W'(1) : {1'b0, w_reg};
        end

        step_val = step_neg_reg ? -div_quotient : div_quotient;

        rd_next     = cmd.rd_load ? div_quotient : rd_reg;
        step_x_next = cmd.step_x_load ? step_val : step_x_reg;
        step_y_next = cmd.step_y_load ? step_val : step_y_reg;

        priority if (cmd.pos_x_load)
            pos_x_next = px_reg + prod_q14[fcg_pkg::FIX_W-1:0];
        else if (cmd.tex_load)
            pos_x_next = pos_x_reg + step_x_reg;
        else
            pos_x_next = pos_x_reg;

        priority if (cmd.pos_y_load)
            pos_y_next = py_reg + prod_q14[fcg_pkg::FIX_W-1:0];
        else if (cmd.tex_load)
            pos_y_next = pos_y_reg + step_y_reg;
        else
            pos_y_next = pos_y_reg;

        out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    fcg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .idle     (div_idle),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg        <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_reg        <= rd_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= row;
            col_reg <= column;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.div_load)
            step_neg_reg <= prod_reg[fcg_pkg::PROD_W-1];
        if (cmd.res_clear)
        begin
            res_tx_reg    <= '0;
            res_ty_reg    <= '0;
            res_floor_reg <= '0;
            res_ceil_reg  <= '0;
            res_drawn_reg <= 1'b0;
        end
        if (cmd.tex_load)
        begin
            res_tx_reg    <= fcg_pkg::texel(pos_x_reg);
            res_ty_reg    <= fcg_pkg::texel(pos_y_reg);
            res_drawn_reg <= 1'b1;
        end
        if (cmd.floor_load)
            res_floor_reg <= prod_reg[fcg_pkg::ADDR_W-1:0] + base;
        if (cmd.ceil_load)
            res_ceil_reg <= prod_reg[fcg_pkg::ADDR_W-1:0] + base;
        if (cmd.out_load)
        begin
            out_tx_reg    <= res_tx_reg;
            out_ty_reg    <= res_ty_reg;
            out_floor_reg <= res_floor_reg;
            out_ceil_reg  <= res_ceil_reg;
            out_drawn_reg <= res_drawn_reg;
        end
    end

    always_comb
    begin
        status.below_horizon = row_reg > {1'b0, half_h};
        status.col_zero      = (col_reg == '0);
        status.div_idle      = div_idle;
        status.out_free      = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign tex_x         = out_tx_reg;
    assign tex_y         = out_ty_reg;
    assign floor_pixel   = out_floor_reg;
    assign ceiling_pixel = out_ceil_reg;
    assign drawn         = out_drawn_reg;

endmodule

`default_nettype wire

// File: rtl/fcg_ctrl.sv
// Controller state machine: sequences row set-up, texel and address steps.
// Depends on fcg_pkg.
`default_nettype none

module fcg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fcg_pkg::status_t  status,
    output fcg_pkg::cmd_t          cmd
);

    fcg_pkg::state_t state_reg;
    fcg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fcg_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcg_pkg::S_IDLE:
                if (in_valid)
                    state_next = fcg_pkg::S_CHECK;
            fcg_pkg::S_CHECK:
                priority if (!status.below_horizon)
                    state_next = fcg_pkg::S_FINISH;
                else if (status.col_zero)
                    state_next = fcg_pkg::S_RD_WAIT;
                else
                    state_next = fcg_pkg::S_TEX;
            fcg_pkg::S_RD_WAIT:
                if (status.div_idle)
                    state_next = fcg_pkg::S_MUL_FX;
            fcg_pkg::S_MUL_FX:  state_next = fcg_pkg::S_MUL_FY;
            fcg_pkg::S_MUL_FY:  state_next = fcg_pkg::S_MUL_SX;
            fcg_pkg::S_MUL_SX:  state_next = fcg_pkg::S_DIV_SX;
            fcg_pkg::S_DIV_SX:  state_next = fcg_pkg::S_SX_WAIT;
            fcg_pkg::S_SX_WAIT:
                if (status.div_idle)
                    state_next = fcg_pkg::S_SY_WAIT;
            fcg_pkg::S_SY_WAIT:
                if (status.div_idle)
                    state_next = fcg_pkg::S_TEX;
            fcg_pkg::S_TEX:     state_next = fcg_pkg::S_ADDR_F;
            fcg_pkg::S_ADDR_F:  state_next = fcg_pkg::S_ADDR_C;
            fcg_pkg::S_ADDR_C:  state_next = fcg_pkg::S_FINISH;
            fcg_pkg::S_FINISH:
                if (status.out_free)
                    state_next = fcg_pkg::S_IDLE;
            default:            state_next = fcg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            fcg_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            fcg_pkg::S_CHECK:
            begin
                priority if (!status.below_horizon)
                    cmd.res_clear = 1'b1;
                else if (status.col_zero)
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = fcg_pkg::DIV_ROW;
                end
                else
                    cmd.res_clear = 1'b0;
            end
            fcg_pkg::S_RD_WAIT:
                cmd.rd_load = status.div_idle;
            fcg_pkg::S_MUL_FX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fcg_pkg::MUL_FX;
            end
            fcg_pkg::S_MUL_FY:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = fcg_pkg::MUL_FY;
                cmd.pos_x_load = 1'b1;
            end
            fcg_pkg::S_MUL_SX:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = fcg_pkg::MUL_SX;
                cmd.pos_y_load = 1'b1;
            end
            fcg_pkg::S_DIV_SX:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = fcg_pkg::DIV_STEP;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = fcg_pkg::MUL_SY;
            end
            fcg_pkg::S_SX_WAIT:
            begin
                cmd.div_src     = fcg_pkg::DIV_STEP;
                cmd.step_x_load = status.div_idle;
                cmd.div_load    = status.div_idle;
            end
            fcg_pkg::S_SY_WAIT:
                cmd.step_y_load = status.div_idle;
            fcg_pkg::S_TEX:
            begin
                cmd.tex_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = fcg_pkg::MUL_AF;
            end
            fcg_pkg::S_ADDR_F:
            begin
                cmd.floor_load = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = fcg_pkg::MUL_AC;
            end
            fcg_pkg::S_ADDR_C:
                cmd.ceil_load = 1'b1;
            fcg_pkg::S_FINISH:
                cmd.out_load = status.out_free;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register loaded while occupied");

    a_div_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> status.div_idle)
        else $error("divider restarted while busy");

    a_step_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_x_load || cmd.step_y_load || cmd.rd_load) |-> status.div_idle)
        else $error("quotient taken before divide finished");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == fcg_pkg::S_CHECK))
        else $error("accepted transaction not processed");
`endif

endmodule

`default_nettype wire

// File: rtl/floor_ceiling_texel_generator_unit.sv
// Top level of the floor/ceiling texel generator.
// Depends on fcg_pkg, fcg_ctrl, fcg_dp (and fcg_div inside fcg_dp).
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_stall    row, column
//   out      out  out_valid / out_stall  tex_x, tex_y, floor_pixel, ceiling_pixel, drawn
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel at a time, taken only in the idle state. A pixel not starting a row
// steps through the check, texel, floor address, ceiling address and final states;
// at or above the horizon the check clears the result and skips to the final state.
// Column 0 adds the row set-up: three passes of the shared bit-serial divider.
// Output register holds a result under out_stall while the next pixel is taken;
// the final state then waits for as long as out_stall keeps the register full.
// Reset restores the register defaults and clears the row state; cfg_ready is always 1.
`default_nettype none

module floor_ceiling_texel_generator_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [fcg_pkg::DIM_W-1:0]         row,
    input  wire logic [fcg_pkg::DIM_W-1:0]         column,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [fcg_pkg::TEX_W-1:0]              tex_x,
    output logic [fcg_pkg::TEX_W-1:0]              tex_y,
    output logic [fcg_pkg::ADDR_W-1:0]             floor_pixel,
    output logic [fcg_pkg::ADDR_W-1:0]             ceiling_pixel,
    output logic                                   drawn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fcg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fcg_pkg::cmd_t    cmd;
    fcg_pkg::status_t status;

    assign cfg_ready = 1'b1;

    fcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fcg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .row           (row),
        .column        (column),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .tex_x         (tex_x),
        .tex_y         (tex_y),
        .floor_pixel   (floor_pixel),
        .ceiling_pixel (ceiling_pixel),
        .drawn         (drawn)
    );

endmodule

`default_nettype wire
